FILE: rtl/dht_pkg.sv
// Shared types, codes and default sizes of the double hashing table.
package dht_pkg;

    localparam int TABLE_SLOTS_DEF = 13;
    localparam int STEP_PRIME_DEF  = 7;
    localparam int KEY_BITS_DEF    = 16;

    localparam int KEY_W  = 16;
    localparam int SLOT_W = 4;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } rsp_t;

    typedef struct packed {
        logic    load;
        logic    hash;
        logic    setup;
        logic    issue;
        logic    finish;
        logic    write;
        logic    emit;
        status_t fin_status;
        logic    fin_slot;
    } cmd_t;

    typedef struct packed {
        logic search;
        logic full;
        logic rd_used;
        logic rd_match;
        logic rd_last;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/dht_ctrl.sv
// Control state machine that sequences hashing, probing and result hand-off.
module dht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dht_pkg::stat_t stat,
    output dht_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_SETUP,
        S_ISSUE,
        S_PROBE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.fin_status = dht_pkg::ST_MISSING;
        req_stall      = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                if (!stat.search && stat.full)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = dht_pkg::ST_FULL;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.issue = 1'b1;
                priority if (!stat.rd_used)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESULT;
                    if (stat.search)
                    begin
                        cmd.fin_status = dht_pkg::ST_MISSING;
                    end
                    else
                    begin
                        cmd.fin_status = dht_pkg::ST_INSERTED;
                        cmd.fin_slot   = 1'b1;
                        cmd.write      = 1'b1;
                    end
                end
                else if (stat.search && stat.rd_match)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = dht_pkg::ST_FOUND;
                    cmd.fin_slot   = 1'b1;
                    state_next     = S_RESULT;
                end
                else if (stat.rd_last)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = stat.search ? dht_pkg::ST_MISSING : dht_pkg::ST_FULL;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!stat.rd_used && !stat.search))
        else $error("insert written over an occupied slot");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (req_stall && !cmd.emit))
        else $error("new transaction taken while one is in flight");

endmodule

FILE: rtl/dht_dpath.sv
// Datapath: key hashing, probe address sequence, key store, slot flags and result registers.
module dht_dpath #(
    parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS_DEF,
    parameter int STEP_PRIME  = dht_pkg::STEP_PRIME_DEF,
    parameter int KEY_BITS    = dht_pkg::KEY_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dht_pkg::req_t req,
    output dht_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  dht_pkg::cmd_t cmd,
    output dht_pkg::stat_t stat
);

    localparam int KW  = (KEY_BITS < dht_pkg::KEY_W) ? KEY_BITS : dht_pkg::KEY_W;
    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int FW  = $clog2(TABLE_SLOTS + 1);
    localparam int PW  = (STEP_PRIME > 2) ? $clog2(STEP_PRIME) : 1;
    localparam int MW  = KW + 32;
    localparam int RW  = KW + 8;
    localparam logic [63:0] RECIP_ONE  = 64'd1 << 32;
    localparam logic [31:0] HOME_RECIP = 32'(RECIP_ONE / TABLE_SLOTS);
    localparam logic [31:0] STEP_RECIP = 32'(RECIP_ONE / STEP_PRIME);

    logic [KW-1:0]          key_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [FW-1:0]          fill_reg;

    logic                   mode_reg;
    logic [KW-1:0]          key_reg;
    logic [MW-1:0]          prod_home_reg;
    logic [MW-1:0]          prod_step_reg;
    logic [SW-1:0]          pos_reg;
    logic [SW-1:0]          step_reg;
    logic [SW-1:0]          cnt_reg;

    logic [KW-1:0]          rd_key_reg;
    logic                   rd_used_reg;
    logic [SW-1:0]          rd_pos_reg;
    logic                   rd_last_reg;

    dht_pkg::status_t       res_status_reg;
    logic [dht_pkg::SLOT_W-1:0] res_slot_reg;
    dht_pkg::rsp_t          rsp_reg;
    logic                   out_valid_reg;

    logic [SW-1:0]          step_rom [STEP_PRIME];

    logic [KW-1:0]          q_home;
    logic [KW-1:0]          q_step;
    logic [RW-1:0]          diff_home;
    logic [RW-1:0]          diff_step;
    logic [RW-1:0]          rem_home;
    logic [RW-1:0]          rem_step;
    logic [SW:0]            pos_sum;
    logic [SW-1:0]          pos_next;
    logic [SW+dht_pkg::SLOT_W-1:0] pos_ext;

    for (genvar g = 0; g < STEP_PRIME; g++)
    begin : g_step_rom
        assign step_rom[g] = SW'((STEP_PRIME - g) % TABLE_SLOTS);
    end

    always_comb
    begin
        q_home    = prod_home_reg[MW-1:32];
        q_step    = prod_step_reg[MW-1:32];
        diff_home = RW'(key_reg) - RW'(q_home) * RW'(TABLE_SLOTS);
        diff_step = RW'(key_reg) - RW'(q_step) * RW'(STEP_PRIME);
        rem_home  = (diff_home >= RW'(TABLE_SLOTS)) ? diff_home - RW'(TABLE_SLOTS) : diff_home;
        rem_step  = (diff_step >= RW'(STEP_PRIME)) ? diff_step - RW'(STEP_PRIME) : diff_step;
        pos_sum   = (SW+1)'(pos_reg) + (SW+1)'(step_reg);
        pos_next  = (pos_sum >= (SW+1)'(TABLE_SLOTS)) ?
                    SW'(pos_sum - (SW+1)'(TABLE_SLOTS)) : SW'(pos_sum);
        pos_ext   = (SW+dht_pkg::SLOT_W)'(rd_pos_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req.mode;
            key_reg  <= req.key[KW-1:0];
        end
        if (cmd.hash)
        begin
            prod_home_reg <= MW'(key_reg) * MW'(HOME_RECIP);
            prod_step_reg <= MW'(key_reg) * MW'(STEP_RECIP);
        end
        if (cmd.setup)
        begin
            pos_reg  <= SW'(rem_home);
            step_reg <= step_rom[PW'(rem_step)];
            cnt_reg  <= '0;
        end
        else if (cmd.issue)
        begin
            rd_key_reg  <= key_mem[pos_reg];
            rd_used_reg <= used_reg[pos_reg];
            rd_pos_reg  <= pos_reg;
            rd_last_reg <= (cnt_reg == SW'(TABLE_SLOTS - 1));
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            res_status_reg <= cmd.fin_status;
            res_slot_reg   <= cmd.fin_slot ? pos_ext[dht_pkg::SLOT_W-1:0] : '0;
        end
        if (cmd.emit)
        begin
            rsp_reg.status <= res_status_reg;
            rsp_reg.slot   <= res_slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            key_mem[rd_pos_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                used_reg[rd_pos_reg] <= 1'b1;
                fill_reg             <= fill_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.search   = (mode_reg == dht_pkg::MODE_SEARCH);
    assign stat.full     = (fill_reg == FW'(TABLE_SLOTS));
    assign stat.rd_used  = rd_used_reg;
    assign stat.rd_match = (rd_key_reg == key_reg);
    assign stat.rd_last  = rd_last_reg;
    assign stat.out_free = !out_valid_reg || !rsp_stall;

    assign rsp       = rsp_reg;
    assign rsp_valid = out_valid_reg;

    a_fill_tracks_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(fill_reg))
        else $error("fill count disagrees with occupied slots");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (fill_reg < FW'(TABLE_SLOTS)))
        else $error("insert written into a full table");

endmodule

FILE: rtl/double_hash_table_core.sv
// Top level of the double hashing table: controller plus datapath.
// Each transaction inserts or searches one key in an open-addressing table of TABLE_SLOTS
// slots; the home slot is key mod TABLE_SLOTS and the probe step is STEP_PRIME minus key mod
// STEP_PRIME. One item is handled at a time; 1 to TABLE_SLOTS slots are probed, and an
// insert into a full table is rejected in the setup state without probing. The idle state
// takes the transaction, the hash and setup states compute both hashes, the issue state
// addresses the key store, the probe state reads one slot per cycle through its single
// read port, and the result state hands the result to the output register once it is free;
// the output register holds a finished result while the next transaction is accepted.
// After reset every slot is empty; no clearing pass is needed.
module double_hash_table_core #(
    parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS_DEF,
    parameter int STEP_PRIME  = dht_pkg::STEP_PRIME_DEF,
    parameter int KEY_BITS    = dht_pkg::KEY_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dht_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dht_pkg::rsp_t rsp
);

    dht_pkg::cmd_t  cmd;
    dht_pkg::stat_t stat;

    dht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dht_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .STEP_PRIME  (STEP_PRIME),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
